// ===== design/lfhs_pkg.sv =====
// Shared types, constants and helpers of the line-follow heading sequencer.
package lfhs_pkg;

	// Sensor array.
	localparam int SENSOR_COUNT = 8;
	localparam int SCAN_COUNT   = (SENSOR_COUNT < 8) ? SENSOR_COUNT : 8;
	localparam int CNT_W        = $clog2(SCAN_COUNT + 1);
	localparam int REM_W        = $clog2(SCAN_COUNT);

	// Field and datapath widths.
	localparam int MASK_W   = 8;
	localparam int CUR_W    = 16;
	localparam int ANG_W    = 17;
	localparam int ERR_W    = 11;
	localparam int GAIN_W   = 11;
	localparam int LEAD_W   = 15;
	localparam int FAIL_W   = 16;
	localparam int ACT_W    = 3;
	localparam int SUM_W    = 14;
	localparam int DIV_BITS = 13;
	localparam int STEP_W   = $clog2(DIV_BITS + 1);
	localparam int PROD_W   = ERR_W + GAIN_W;
	localparam int WIDE_W   = 20;
	localparam int GAIN_FRAC = 8;

	// Angles in 1/128 degree.
	localparam logic signed [WIDE_W-1:0] ANG_HALF = 20'sd23040;
	localparam logic signed [WIDE_W-1:0] ANG_FULL = 20'sd46080;

	// Sensor weights in 1/128 units for the eight-sensor bar.
	localparam logic signed [SUM_W-1:0] WEIGHT8 [8] = '{
		-14'sd576, -14'sd384, -14'sd192, -14'sd64,
		14'sd64, 14'sd192, 14'sd384, 14'sd576
	};

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_STEER_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LEAD_LIMIT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_FAIL_LIMIT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_MASK  = 3'd3;
	localparam logic [IDX_W-1:0] REG_LEFT_MASK    = 3'd4;
	localparam logic [IDX_W-1:0] REG_RIGHT_MASK   = 3'd5;

	localparam logic signed [GAIN_W-1:0] RST_STEER_GAIN  = -11'sd154;
	localparam logic [LEAD_W-1:0]        RST_LEAD_LIMIT  = 15'd4480;
	localparam logic [FAIL_W-1:0]        RST_FAIL_LIMIT  = 16'd10;
	localparam logic [MASK_W-1:0]        RST_CENTER_MASK = 8'd24;
	localparam logic [MASK_W-1:0]        RST_LEFT_MASK   = 8'd15;
	localparam logic [MASK_W-1:0]        RST_RIGHT_MASK  = 8'd240;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALARM       = 3'd0,
		ACT_LOST        = 3'd1,
		ACT_RECOVERED   = 3'd2,
		ACT_LEFT_BEGIN  = 3'd3,
		ACT_RIGHT_BEGIN = 3'd4,
		ACT_TURNING     = 3'd5,
		ACT_TURN_DONE   = 3'd6,
		ACT_TRACKING    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_LEFT  = 2'd1,
		TURN_RIGHT = 2'd2
	} turn_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_DIV_END,
		ST_MUL,
		ST_ADD,
		ST_CLAMP,
		ST_WRAP,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] steer_gain;
		logic [LEAD_W-1:0]        lead_limit;
		logic [FAIL_W-1:0]        fail_limit;
		logic [MASK_W-1:0]        center_mask;
		logic [MASK_W-1:0]        left_mask;
		logic [MASK_W-1:0]        right_mask;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic div_step;
		logic err_load;
		logic mul;
		logic add;
		logic clamp;
		logic wrap;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic track;
		logic cnt_zero;
	} dp_stat_t;

	function automatic logic signed [SUM_W-1:0] sensor_weight(input int i);
		if (SENSOR_COUNT == 8) begin
			return WEIGHT8[i[2:0]];
		end
		return SUM_W'((2 * i - (SENSOR_COUNT - 1)) * 64);
	endfunction

endpackage

// ===== design/lfhs_regs.sv =====
// Configuration register file behind the APB-style port.
module lfhs_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lfhs_pkg::ADDR_W-1:0] paddr,
	input  logic [lfhs_pkg::DATA_W-1:0] pwdata,
	output logic [lfhs_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output lfhs_pkg::cfg_t             cfg
);

	lfhs_pkg::cfg_t              cfg_q;
	logic [lfhs_pkg::IDX_W-1:0]  idx;

	assign idx    = paddr[lfhs_pkg::ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_gain  <= lfhs_pkg::RST_STEER_GAIN;
			cfg_q.lead_limit  <= lfhs_pkg::RST_LEAD_LIMIT;
			cfg_q.fail_limit  <= lfhs_pkg::RST_FAIL_LIMIT;
			cfg_q.center_mask <= lfhs_pkg::RST_CENTER_MASK;
			cfg_q.left_mask   <= lfhs_pkg::RST_LEFT_MASK;
			cfg_q.right_mask  <= lfhs_pkg::RST_RIGHT_MASK;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				lfhs_pkg::REG_STEER_GAIN: begin
					cfg_q.steer_gain <= $signed(pwdata[lfhs_pkg::GAIN_W-1:0]);
				end
				lfhs_pkg::REG_LEAD_LIMIT: begin
					cfg_q.lead_limit <= pwdata[lfhs_pkg::LEAD_W-1:0];
				end
				lfhs_pkg::REG_FAIL_LIMIT: begin
					cfg_q.fail_limit <= pwdata[lfhs_pkg::FAIL_W-1:0];
				end
				lfhs_pkg::REG_CENTER_MASK: begin
					cfg_q.center_mask <= pwdata[lfhs_pkg::MASK_W-1:0];
				end
				lfhs_pkg::REG_LEFT_MASK: begin
					cfg_q.left_mask <= pwdata[lfhs_pkg::MASK_W-1:0];
				end
				lfhs_pkg::REG_RIGHT_MASK: begin
					cfg_q.right_mask <= pwdata[lfhs_pkg::MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lfhs_pkg::REG_STEER_GAIN:  prdata = lfhs_pkg::DATA_W'(cfg_q.steer_gain);
			lfhs_pkg::REG_LEAD_LIMIT:  prdata = lfhs_pkg::DATA_W'(cfg_q.lead_limit);
			lfhs_pkg::REG_FAIL_LIMIT:  prdata = lfhs_pkg::DATA_W'(cfg_q.fail_limit);
			lfhs_pkg::REG_CENTER_MASK: prdata = lfhs_pkg::DATA_W'(cfg_q.center_mask);
			lfhs_pkg::REG_LEFT_MASK:   prdata = lfhs_pkg::DATA_W'(cfg_q.left_mask);
			lfhs_pkg::REG_RIGHT_MASK:  prdata = lfhs_pkg::DATA_W'(cfg_q.right_mask);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== design/lfhs_dp.sv =====
// Datapath: sensor qualification, mode decision, centroid divider and heading update.
module lfhs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfhs_pkg::cfg_t                    cfg,
	input  lfhs_pkg::dp_cmd_t                 cmd,
	output lfhs_pkg::dp_stat_t                stat,
	input  logic                              read_ok,
	input  logic [lfhs_pkg::MASK_W-1:0]       raw_byte,
	input  logic signed [lfhs_pkg::CUR_W-1:0] current_heading,
	input  logic                              alarm,
	output logic [lfhs_pkg::ACT_W-1:0]        action,
	output logic signed [lfhs_pkg::ANG_W-1:0] target_heading,
	output logic signed [lfhs_pkg::ERR_W-1:0] line_error,
	output logic [lfhs_pkg::MASK_W-1:0]       sensor_value,
	output logic                              turning,
	output logic                              lost,
	output logic                              turn_right
);

	// Captured input beat.
	logic                               ok_q;
	logic [lfhs_pkg::MASK_W-1:0]        raw_q;
	logic signed [lfhs_pkg::CUR_W-1:0]  cur_q;
	logic                               alarm_q;

	// Sequencer state.
	logic [lfhs_pkg::MASK_W-1:0]        cache_q;
	logic [lfhs_pkg::FAIL_W-1:0]        fail_q;
	logic signed [lfhs_pkg::ANG_W-1:0]  target_q;
	logic signed [lfhs_pkg::ERR_W-1:0]  err_q;
	logic                               lost_q;
	lfhs_pkg::turn_t                    turn_q;

	// Per-beat working registers.
	lfhs_pkg::action_t                  act_q;
	logic [lfhs_pkg::MASK_W-1:0]        sens_q;
	logic [lfhs_pkg::DIV_BITS-1:0]      dvd_q;
	logic [lfhs_pkg::REM_W-1:0]         rem_q;
	logic [lfhs_pkg::CNT_W-1:0]         dsr_q;
	logic                               neg_q;
	logic signed [lfhs_pkg::PROD_W-1:0] prod_q;
	logic signed [lfhs_pkg::WIDE_W-1:0] t_q;

	// Result register.
	lfhs_pkg::action_t                  out_act_q;
	logic signed [lfhs_pkg::ANG_W-1:0]  out_tgt_q;
	logic signed [lfhs_pkg::ERR_W-1:0]  out_err_q;
	logic [lfhs_pkg::MASK_W-1:0]        out_sens_q;
	logic                               out_turning_q;
	logic                               out_lost_q;
	logic                               out_right_q;

	// Decision logic.
	logic                               turning_now;
	logic                               fetch_en;
	logic [lfhs_pkg::FAIL_W-1:0]        fail_inc;
	logic [lfhs_pkg::MASK_W-1:0]        s_fetch;
	logic [lfhs_pkg::MASK_W-1:0]        s_e;
	logic [lfhs_pkg::MASK_W-1:0]        cache_n;
	logic [lfhs_pkg::FAIL_W-1:0]        fail_n;
	lfhs_pkg::turn_t                    turn_n;
	logic                               lost_n;
	lfhs_pkg::action_t                  act_n;
	logic                               tgt_set;
	logic                               track;

	// Centroid and arithmetic.
	logic signed [lfhs_pkg::SUM_W-1:0]  sum;
	logic [lfhs_pkg::CNT_W-1:0]         cnt;
	logic [lfhs_pkg::SUM_W-1:0]         mag;
	logic [lfhs_pkg::REM_W:0]           trial;
	logic                               ge;
	logic [lfhs_pkg::REM_W:0]           rem_n;
	logic signed [lfhs_pkg::ERR_W-1:0]  quo;
	logic signed [lfhs_pkg::WIDE_W-1:0] cur_w;
	logic signed [lfhs_pkg::WIDE_W-1:0] lim_w;
	logic signed [lfhs_pkg::WIDE_W-1:0] diff;
	logic signed [lfhs_pkg::WIDE_W-1:0] wrapped;

	assign turning_now = (turn_q == lfhs_pkg::TURN_LEFT) || (turn_q == lfhs_pkg::TURN_RIGHT);
	assign fetch_en    = turning_now || !alarm_q;
	assign fail_inc    = (fail_q == '1) ? fail_q : fail_q + lfhs_pkg::FAIL_W'(1);

	always_comb begin
		if (ok_q) begin
			s_fetch = ~raw_q;
			cache_n = ~raw_q;
			fail_n  = '0;
		end else begin
			s_fetch = (fail_inc > cfg.fail_limit) ? '0 : cache_q;
			cache_n = cache_q;
			fail_n  = fail_inc;
		end
		if (!fetch_en) begin
			s_e     = '0;
			cache_n = cache_q;
			fail_n  = fail_q;
		end else begin
			s_e = s_fetch;
		end
	end

	always_comb begin
		turn_n  = lfhs_pkg::TURN_NONE;
		lost_n  = lost_q;
		act_n   = lfhs_pkg::ACT_ALARM;
		tgt_set = 1'b0;
		track   = 1'b0;
		if (turning_now) begin
			if ((s_e & cfg.center_mask) != '0) begin
				tgt_set = 1'b1;
				act_n   = lfhs_pkg::ACT_TURN_DONE;
			end else if (alarm_q) begin
				act_n = lfhs_pkg::ACT_ALARM;
			end else begin
				turn_n = turn_q;
				act_n  = lfhs_pkg::ACT_TURNING;
			end
		end else begin
			priority if (alarm_q) begin
				act_n = lfhs_pkg::ACT_ALARM;
			end else if (s_e == '0) begin
				lost_n = 1'b1;
				act_n  = lfhs_pkg::ACT_LOST;
			end else if (lost_q) begin
				tgt_set = 1'b1;
				lost_n  = 1'b0;
				act_n   = lfhs_pkg::ACT_RECOVERED;
			end else if ((s_e & cfg.left_mask) == cfg.left_mask) begin
				turn_n = lfhs_pkg::TURN_LEFT;
				act_n  = lfhs_pkg::ACT_LEFT_BEGIN;
			end else if ((s_e & cfg.right_mask) == cfg.right_mask) begin
				turn_n = lfhs_pkg::TURN_RIGHT;
				act_n  = lfhs_pkg::ACT_RIGHT_BEGIN;
			end else begin
				track = 1'b1;
				act_n = lfhs_pkg::ACT_TRACKING;
			end
		end
	end

	// Weighted sum and bit count of the qualified reading.
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int i = 0; i < lfhs_pkg::SCAN_COUNT; i++) begin
			if (s_e[i]) begin
				sum = sum + lfhs_pkg::sensor_weight(i);
				cnt = cnt + lfhs_pkg::CNT_W'(1);
			end
		end
		mag = sum[lfhs_pkg::SUM_W-1] ? lfhs_pkg::SUM_W'(-sum) : lfhs_pkg::SUM_W'(sum);
	end

	assign stat.track    = track;
	assign stat.cnt_zero = (cnt == '0);

	// One quotient bit per cycle on the magnitude; the sign goes back on at the end.
	assign trial = {rem_q, dvd_q[lfhs_pkg::DIV_BITS-1]};
	assign ge    = (trial >= (lfhs_pkg::REM_W+1)'(dsr_q));
	assign rem_n = ge ? trial - (lfhs_pkg::REM_W+1)'(dsr_q) : trial;
	assign quo   = $signed(dvd_q[lfhs_pkg::ERR_W-1:0]);

	assign cur_w = lfhs_pkg::WIDE_W'(cur_q);
	assign lim_w = $signed(lfhs_pkg::WIDE_W'(cfg.lead_limit));
	assign diff  = t_q - cur_w;

	always_comb begin
		if (t_q > lfhs_pkg::ANG_HALF) begin
			wrapped = t_q - lfhs_pkg::ANG_FULL;
		end else if (t_q < -lfhs_pkg::ANG_HALF) begin
			wrapped = t_q + lfhs_pkg::ANG_FULL;
		end else begin
			wrapped = t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_q  <= lfhs_pkg::RST_CENTER_MASK;
			fail_q   <= '0;
			target_q <= '0;
			err_q    <= '0;
			lost_q   <= 1'b0;
			turn_q   <= lfhs_pkg::TURN_NONE;
		end else begin
			if (cmd.eval) begin
				cache_q <= cache_n;
				fail_q  <= fail_n;
				lost_q  <= lost_n;
				turn_q  <= turn_n;
				if (tgt_set) begin
					target_q <= lfhs_pkg::ANG_W'(cur_q);
				end
			end
			if (cmd.err_load) begin
				err_q <= neg_q ? -quo : quo;
			end
			if (cmd.wrap) begin
				target_q <= $signed(wrapped[lfhs_pkg::ANG_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q    <= read_ok;
			raw_q   <= raw_byte;
			cur_q   <= current_heading;
			alarm_q <= alarm;
		end
		if (cmd.eval) begin
			act_q  <= act_n;
			sens_q <= s_e;
			dvd_q  <= mag[lfhs_pkg::DIV_BITS-1:0];
			rem_q  <= '0;
			dsr_q  <= cnt;
			neg_q  <= sum[lfhs_pkg::SUM_W-1];
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[lfhs_pkg::DIV_BITS-2:0], ge};
			rem_q <= rem_n[lfhs_pkg::REM_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= err_q * cfg.steer_gain;
		end
		if (cmd.add) begin
			t_q <= lfhs_pkg::WIDE_W'(target_q) + lfhs_pkg::WIDE_W'(prod_q >>> lfhs_pkg::GAIN_FRAC);
		end
		if (cmd.clamp) begin
			if (diff > lim_w) begin
				t_q <= cur_w + lim_w;
			end else if (diff < -lim_w) begin
				t_q <= cur_w - lim_w;
			end
		end
		if (cmd.out_load) begin
			out_act_q     <= act_q;
			out_tgt_q     <= target_q;
			out_err_q     <= err_q;
			out_sens_q    <= sens_q;
			out_turning_q <= (turn_q != lfhs_pkg::TURN_NONE);
			out_lost_q    <= lost_q;
			out_right_q   <= (turn_q == lfhs_pkg::TURN_RIGHT);
		end
	end

	assign action         = out_act_q;
	assign target_heading = out_tgt_q;
	assign line_error     = out_err_q;
	assign sensor_value   = out_sens_q;
	assign turning        = out_turning_q;
	assign lost           = out_lost_q;
	assign turn_right     = out_right_q;

	// A lost line is only ever declared outside a corner turn.
	a_lost_not_turning: assert property (@(posedge clk) disable iff (!arst_n)
		!(lost_q && (turn_q != lfhs_pkg::TURN_NONE)))
		else $error("lost flag set during a corner turn");

	// An alarm outside a turn takes no read, so the failure count must hold.
	a_alarm_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && alarm_q && (turn_q == lfhs_pkg::TURN_NONE)) |=> $stable(fail_q))
		else $error("failure count moved on an alarm step");

	// The turn mode only ever holds one of its three defined values.
	a_turn_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(turn_q == lfhs_pkg::TURN_NONE) || (turn_q == lfhs_pkg::TURN_LEFT) ||
		(turn_q == lfhs_pkg::TURN_RIGHT))
		else $error("turn mode left its defined values");

endmodule

// ===== design/lfhs_ctrl.sv =====
// Controller state machine that sequences the datapath for each beat.
module lfhs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  lfhs_pkg::dp_stat_t stat,
	output lfhs_pkg::dp_cmd_t  cmd
);

	lfhs_pkg::state_t            state_q;
	lfhs_pkg::state_t            state_n;
	logic [lfhs_pkg::STEP_W-1:0] cnt_q;
	logic                        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfhs_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lfhs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = lfhs_pkg::ST_EVAL;
				end
			end
			lfhs_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				if (!stat.track) begin
					state_n = lfhs_pkg::ST_RESULT;
				end else if (stat.cnt_zero) begin
					// No counted bit: the previous error is kept.
					state_n = lfhs_pkg::ST_MUL;
				end else begin
					state_n = lfhs_pkg::ST_DIV;
				end
			end
			lfhs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == lfhs_pkg::STEP_W'(lfhs_pkg::DIV_BITS - 1)) begin
					state_n = lfhs_pkg::ST_DIV_END;
				end
			end
			lfhs_pkg::ST_DIV_END: begin
				cmd.err_load = 1'b1;
				state_n      = lfhs_pkg::ST_MUL;
			end
			lfhs_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = lfhs_pkg::ST_ADD;
			end
			lfhs_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				state_n = lfhs_pkg::ST_CLAMP;
			end
			lfhs_pkg::ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_n   = lfhs_pkg::ST_WRAP;
			end
			lfhs_pkg::ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_n  = lfhs_pkg::ST_RESULT;
			end
			lfhs_pkg::ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_n      = lfhs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = lfhs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.eval) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + lfhs_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == lfhs_pkg::ST_EVAL))
		else $error("accepted beat not evaluated next cycle");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfhs_pkg::ST_DIV) |-> (cnt_q < lfhs_pkg::DIV_BITS))
		else $error("divider ran past its last quotient bit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while still held");

endmodule

// ===== design/line_follow_heading_sequencer_unit.sv =====
// Top level of the line-follow heading sequencer.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_stall     read_ok, raw_byte, current_heading, alarm
//   out      source     out_valid / out_stall   action, target_heading, line_error,
//                                               sensor_value, turning, lost, turn_right
//   cfg      sink       psel/penable/pwrite     paddr, pwdata, prdata (pready always high)
//
// One beat is taken at a time. Alarm, lost, recovery, corner and turning steps go from
// evaluation straight to the result state; a tracking step first runs the restoring
// divider (one quotient bit a cycle), then error load, multiply, add, clamp and wrap.
// A new beat is accepted while the previous result still waits in the output register.
// Reset clears sequencer state (cache: centre mask) and loads the register reset values.
// A stalled output holds the controller in its result state until the register frees.
module line_follow_heading_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              read_ok,
	input  logic [lfhs_pkg::MASK_W-1:0]       raw_byte,
	input  logic signed [lfhs_pkg::CUR_W-1:0] current_heading,
	input  logic                              alarm,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lfhs_pkg::ACT_W-1:0]        action,
	output logic signed [lfhs_pkg::ANG_W-1:0] target_heading,
	output logic signed [lfhs_pkg::ERR_W-1:0] line_error,
	output logic [lfhs_pkg::MASK_W-1:0]       sensor_value,
	output logic                              turning,
	output logic                              lost,
	output logic                              turn_right,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lfhs_pkg::ADDR_W-1:0]       paddr,
	input  logic [lfhs_pkg::DATA_W-1:0]       pwdata,
	output logic [lfhs_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	lfhs_pkg::cfg_t     cfg;
	lfhs_pkg::dp_cmd_t  cmd;
	lfhs_pkg::dp_stat_t stat;

	lfhs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lfhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfhs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.stat            (stat),
		.read_ok         (read_ok),
		.raw_byte        (raw_byte),
		.current_heading (current_heading),
		.alarm           (alarm),
		.action          (action),
		.target_heading  (target_heading),
		.line_error      (line_error),
		.sensor_value    (sensor_value),
		.turning         (turning),
		.lost            (lost),
		.turn_right      (turn_right)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the line-follow heading sequencer: directed table and random phases.
module testbench;
	import lfhs_pkg::*;

	localparam int HALF_TURN        = 23040;
	localparam int FULL_TURN        = 46080;
	localparam int STALL_LIMIT      = 2000;
	localparam int SETTLE_CYCLES    = 30;
	localparam int RANDOM_PHASES    = 6;
	localparam int READS_PER_PHASE  = 250;

	typedef struct packed {
		action_t                 act;
		logic signed [ANG_W-1:0] tgt;
		logic signed [ERR_W-1:0] err;
		logic [MASK_W-1:0]       sens;
		logic                    turning;
		logic                    lost;
		logic                    tright;
	} heading_result_t;

	typedef struct packed {
		logic                    ok;
		logic [MASK_W-1:0]       raw;
		logic signed [CUR_W-1:0] cur;
		logic                    alm;
		int                      reps;
		bit                      typed;
		action_t                 t_act;
		logic [MASK_W-1:0]       t_sens;
	} reading_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    read_ok;
	logic [MASK_W-1:0]       raw_byte;
	logic signed [CUR_W-1:0] current_heading;
	logic                    alarm;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ACT_W-1:0]        action;
	logic signed [ANG_W-1:0] target_heading;
	logic signed [ERR_W-1:0] line_error;
	logic [MASK_W-1:0]       sensor_value;
	logic                    turning;
	logic                    lost;
	logic                    turn_right;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	// Register copies kept by the predictor.
	logic signed [GAIN_W-1:0] cfg_gain;
	logic [LEAD_W-1:0]        cfg_lead;
	logic [FAIL_W-1:0]        cfg_fail;
	logic [MASK_W-1:0]        cfg_center;
	logic [MASK_W-1:0]        cfg_left;
	logic [MASK_W-1:0]        cfg_right;

	// Sequencer state kept by the predictor.
	logic [MASK_W-1:0] seq_cache;
	logic [FAIL_W-1:0] seq_fail_run;
	int                seq_target;
	int                seq_error;
	bit                seq_lost;
	turn_t             seq_turn;

	heading_result_t steering_due [$];
	int  act_tally [8];
	int  mismatch_count;
	int  results_seen;
	int  readings_sent;
	int  settings_written;
	int  idle_cycles;
	int  last_heading;
	int  fail_burst_left;
	int  stall_seg_left;
	int  stall_roll;
	bit  quiet;

	// Directed readings, all under the reset register values.
	reading_row_t dir_rows [24] = '{
		'{1'b1, ~8'h18, 16'sd0,      1'b0, 1,  1'b1, ACT_TRACKING,    8'h18},
		'{1'b1, 8'h00,  16'sd23040,  1'b1, 1,  1'b1, ACT_ALARM,       8'h00},
		'{1'b1, 8'hFF,  16'sd0,      1'b0, 1,  1'b1, ACT_LOST,        8'h00},
		'{1'b0, 8'h00,  16'sd100,    1'b0, 1,  1'b1, ACT_LOST,        8'h00},
		'{1'b1, ~8'h18, -16'sd23040, 1'b0, 1,  1'b1, ACT_RECOVERED,   8'h18},
		'{1'b1, ~8'h0F, 16'sd200,    1'b0, 1,  1'b1, ACT_LEFT_BEGIN,  8'h0F},
		'{1'b1, ~8'h01, 16'sd300,    1'b0, 1,  1'b1, ACT_TURNING,     8'h01},
		'{1'b0, 8'h55,  16'sd400,    1'b0, 1,  1'b1, ACT_TURNING,     8'h01},
		'{1'b1, 8'hFF,  16'sd500,    1'b0, 1,  1'b1, ACT_TURNING,     8'h00},
		'{1'b1, ~8'h08, 16'sd5000,   1'b0, 1,  1'b1, ACT_TURN_DONE,   8'h08},
		'{1'b1, ~8'hF0, 16'sd5100,   1'b0, 1,  1'b1, ACT_RIGHT_BEGIN, 8'hF0},
		'{1'b1, ~8'h02, 16'sd5200,   1'b1, 1,  1'b1, ACT_ALARM,       8'h02},
		'{1'b1, ~8'hF0, 16'sd5300,   1'b0, 1,  1'b1, ACT_RIGHT_BEGIN, 8'hF0},
		'{1'b1, ~8'h10, -16'sd300,   1'b1, 1,  1'b1, ACT_TURN_DONE,   8'h10},
		'{1'b1, ~8'h80, 16'sd23040,  1'b0, 1,  1'b0, ACT_TRACKING,    8'h80},
		'{1'b1, ~8'h01, -16'sd23040, 1'b0, 1,  1'b0, ACT_TRACKING,    8'h01},
		'{1'b1, ~8'h81, 16'sd0,      1'b0, 1,  1'b0, ACT_TRACKING,    8'h81},
		'{1'b1, ~8'h07, 16'sd1000,   1'b0, 1,  1'b0, ACT_TRACKING,    8'h07},
		'{1'b1, ~8'hE0, -16'sd1000,  1'b0, 1,  1'b0, ACT_TRACKING,    8'hE0},
		'{1'b0, 8'h00,  16'sd0,      1'b0, 10, 1'b0, ACT_TRACKING,    8'hE0},
		'{1'b0, 8'hFF,  16'sd0,      1'b0, 1,  1'b1, ACT_LOST,        8'h00},
		'{1'b1, ~8'h3C, 16'sd7000,   1'b0, 1,  1'b1, ACT_RECOVERED,   8'h3C},
		'{1'b1, 8'h00,  16'sd7100,   1'b0, 1,  1'b1, ACT_LEFT_BEGIN,  8'hFF},
		'{1'b1, 8'h00,  16'sd7200,   1'b0, 1,  1'b1, ACT_TURN_DONE,   8'hFF}
	};

	line_follow_heading_sequencer_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.read_ok         (read_ok),
		.raw_byte        (raw_byte),
		.current_heading (current_heading),
		.alarm           (alarm),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.action          (action),
		.target_heading  (target_heading),
		.line_error      (line_error),
		.sensor_value    (sensor_value),
		.turning         (turning),
		.lost            (lost),
		.turn_right      (turn_right),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void reset_model();
		cfg_gain     = RST_STEER_GAIN;
		cfg_lead     = RST_LEAD_LIMIT;
		cfg_fail     = RST_FAIL_LIMIT;
		cfg_center   = RST_CENTER_MASK;
		cfg_left     = RST_LEFT_MASK;
		cfg_right    = RST_RIGHT_MASK;
		seq_cache    = RST_CENTER_MASK;
		seq_fail_run = '0;
		seq_target   = 0;
		seq_error    = 0;
		seq_lost     = 1'b0;
		seq_turn     = TURN_NONE;
	endfunction

	// Sensor weight in 1/128 units; the eight-sensor bar is not evenly spaced.
	function automatic int bar_weight(input int i);
		if (SENSOR_COUNT == 8) begin
			case (i)
				0: return -576;
				1: return -384;
				2: return -192;
				3: return -64;
				4: return 64;
				5: return 192;
				6: return 384;
				default: return 576;
			endcase
		end
		return (2 * i - (SENSOR_COUNT - 1)) * 64;
	endfunction

	// A good read refreshes the cache; a long enough run of failures reads as no line.
	function automatic logic [MASK_W-1:0] qualify_read(input logic ok, input logic [MASK_W-1:0] raw);
		if (ok) begin
			seq_cache    = ~raw;
			seq_fail_run = '0;
			return seq_cache;
		end
		if (seq_fail_run != '1)
			seq_fail_run = seq_fail_run + 1'b1;
		if (seq_fail_run > cfg_fail)
			return '0;
		return seq_cache;
	endfunction

	function automatic void steer_toward_line(input int cur, input logic [MASK_W-1:0] bits);
		int sum;
		int hits;
		int prod;
		int t;
		int lead;
		sum  = 0;
		hits = 0;
		for (int i = 0; i < SENSOR_COUNT && i < 8; i++) begin
			if (bits[i]) begin
				sum  += bar_weight(i);
				hits += 1;
			end
		end
		if (hits > 0)
			seq_error = sum / hits;
		prod = seq_error * cfg_gain;
		t    = seq_target + (prod >>> GAIN_FRAC);
		lead = int'(cfg_lead);
		if (t - cur > lead)
			t = cur + lead;
		if (t - cur < -lead)
			t = cur - lead;
		if (t > HALF_TURN)
			t -= FULL_TURN;
		else if (t < -HALF_TURN)
			t += FULL_TURN;
		seq_target = t;
	endfunction

	function automatic heading_result_t advance_sequencer(input reading_row_t row);
		heading_result_t res;
		logic [MASK_W-1:0] s;
		action_t act;
		int cur;
		s   = '0;
		cur = int'(row.cur);
		if (seq_turn == TURN_LEFT || seq_turn == TURN_RIGHT) begin
			s = qualify_read(row.ok, row.raw);
			if ((s & cfg_center) != '0) begin
				seq_target = cur;
				seq_turn   = TURN_NONE;
				act        = ACT_TURN_DONE;
			end else if (row.alm) begin
				seq_turn = TURN_NONE;
				act      = ACT_ALARM;
			end else begin
				act = ACT_TURNING;
			end
		end else begin
			seq_turn = TURN_NONE;
			if (row.alm) begin
				act = ACT_ALARM;
			end else begin
				s = qualify_read(row.ok, row.raw);
				if (s == '0) begin
					seq_lost = 1'b1;
					act      = ACT_LOST;
				end else if (seq_lost) begin
					seq_target = cur;
					seq_lost   = 1'b0;
					act        = ACT_RECOVERED;
				end else if ((s & cfg_left) == cfg_left) begin
					seq_turn = TURN_LEFT;
					act      = ACT_LEFT_BEGIN;
				end else if ((s & cfg_right) == cfg_right) begin
					seq_turn = TURN_RIGHT;
					act      = ACT_RIGHT_BEGIN;
				end else begin
					steer_toward_line(cur, s);
					act = ACT_TRACKING;
				end
			end
		end
		act_tally[act] += 1;
		res.act     = act;
		res.tgt     = seq_target[ANG_W-1:0];
		res.err     = seq_error[ERR_W-1:0];
		res.sens    = s;
		res.turning = (seq_turn != TURN_NONE);
		res.lost    = seq_lost;
		res.tright  = (seq_turn == TURN_RIGHT);
		return res;
	endfunction

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch in %s on result %0d: expected %0h, got %0h",
				what, results_seen, want, got);
	endfunction

	task automatic program_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_STEER_GAIN:  cfg_gain   = value[GAIN_W-1:0];
			REG_LEAD_LIMIT:  cfg_lead   = value[LEAD_W-1:0];
			REG_FAIL_LIMIT:  cfg_fail   = value[FAIL_W-1:0];
			REG_CENTER_MASK: cfg_center = value[MASK_W-1:0];
			REG_LEFT_MASK:   cfg_left   = value[MASK_W-1:0];
			REG_RIGHT_MASK:  cfg_right  = value[MASK_W-1:0];
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Valid stays high across back-to-back beats; it only drops for a gap.
	task automatic send_reading(input reading_row_t row);
		heading_result_t res;
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		read_ok         <= row.ok;
		raw_byte        <= row.raw;
		current_heading <= row.cur;
		alarm           <= row.alm;
		do @(posedge clk); while (in_stall !== 1'b0);
		res = advance_sequencer(row);
		if (row.typed) begin
			res.act  = row.t_act;
			res.sens = row.t_sens;
		end
		steering_due.push_back(res);
		readings_sent++;
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (steering_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_reading();
		reading_row_t row;
		logic [MASK_W-1:0] s;
		int pick;
		int w;
		int pos;
		int h;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			w   = $urandom_range(1, 3);
			pos = $urandom_range(0, 8 - w);
			s   = 8'(((1 << w) - 1) << pos);
		end else if (pick < 55) begin
			s = cfg_left | (8'($urandom) & 8'($urandom));
		end else if (pick < 65) begin
			s = cfg_right | (8'($urandom) & 8'($urandom));
		end else if (pick < 73) begin
			s = '0;
		end else if (pick < 80) begin
			s = cfg_center;
		end else begin
			s = 8'($urandom);
		end
		if (fail_burst_left > 0) begin
			row.ok = 1'b0;
			fail_burst_left--;
		end else begin
			row.ok = ($urandom_range(0, 19) != 0);
			if ($urandom_range(0, 49) == 0)
				fail_burst_left = $urandom_range(2, 14);
		end
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			h = $urandom_range(0, 1) ? HALF_TURN : -HALF_TURN;
		end else if (pick < 45) begin
			h = last_heading + int'($urandom_range(0, 4000)) - 2000;
			if (h > HALF_TURN)
				h = HALF_TURN;
			if (h < -HALF_TURN)
				h = -HALF_TURN;
		end else begin
			h = int'($urandom_range(0, FULL_TURN)) - HALF_TURN;
		end
		last_heading = h;
		row.raw    = row.ok ? ~s : 8'($urandom);
		row.cur    = CUR_W'(h);
		row.alm    = ($urandom_range(0, 24) == 0);
		row.reps   = 1;
		row.typed  = 1'b0;
		row.t_act  = ACT_TRACKING;
		row.t_sens = '0;
		send_reading(row);
	endtask

	task automatic choose_settings(input int phase);
		case (phase)
			0: return;
			1: begin
				program_register(REG_STEER_GAIN, 32'h0000_0400);
				program_register(REG_LEAD_LIMIT, 32'd0);
				program_register(REG_FAIL_LIMIT, 32'd0);
				program_register(REG_CENTER_MASK, 32'd1);
				program_register(REG_LEFT_MASK, 32'd1);
				program_register(REG_RIGHT_MASK, 32'd1);
			end
			2: begin
				program_register(REG_STEER_GAIN, 32'd1023);
				program_register(REG_LEAD_LIMIT, 32'd23040);
				program_register(REG_FAIL_LIMIT, 32'd65535);
				program_register(REG_CENTER_MASK, 32'd255);
				program_register(REG_LEFT_MASK, 32'd255);
				program_register(REG_RIGHT_MASK, 32'd255);
			end
			default: begin
				program_register(REG_STEER_GAIN, $urandom_range(0, 2047));
				program_register(REG_LEAD_LIMIT, $urandom_range(0, HALF_TURN));
				program_register(REG_FAIL_LIMIT, $urandom_range(0, 12));
				program_register(REG_CENTER_MASK, $urandom_range(1, 255));
				program_register(REG_LEFT_MASK, $urandom_range(1, 255));
				program_register(REG_RIGHT_MASK, $urandom_range(1, 255));
			end
		endcase
		settings_written++;
	endtask

	// Receiver stalls come in segments, mostly short with the odd long hold.
	always @(negedge clk) begin
		if (quiet) begin
			out_stall      <= 1'b0;
			stall_seg_left  = 0;
		end else if (stall_seg_left > 0) begin
			stall_seg_left--;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 30) begin
				out_stall      <= 1'b1;
				stall_seg_left  = $urandom_range(0, 3);
			end else if (stall_roll < 34) begin
				out_stall      <= 1'b1;
				stall_seg_left  = $urandom_range(20, 60);
			end else begin
				out_stall      <= 1'b0;
				stall_seg_left  = $urandom_range(0, 6);
			end
		end
	end

	always @(posedge clk) begin
		heading_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			results_seen++;
			if (steering_due.size() == 0) begin
				flag_mismatch("out_valid with nothing outstanding", 32'd0, 32'd1);
			end else begin
				want = steering_due.pop_front();
				if (want.act !== action)
					flag_mismatch("action", want.act, action);
				if (want.tgt !== target_heading)
					flag_mismatch("target_heading", want.tgt, target_heading);
				if (want.err !== line_error)
					flag_mismatch("line_error", want.err, line_error);
				if (want.sens !== sensor_value)
					flag_mismatch("sensor_value", want.sens, sensor_value);
				if (want.turning !== turning)
					flag_mismatch("turning", want.turning, turning);
				if (want.lost !== lost)
					flag_mismatch("lost", want.lost, lost);
				if (want.tright !== turn_right)
					flag_mismatch("turn_right", want.tright, turn_right);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
				(psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results outstanding",
				idle_cycles, steering_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		read_ok         = 1'b0;
		raw_byte        = '0;
		current_heading = '0;
		alarm           = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		quiet           = 1'b0;
		mismatch_count  = 0;
		results_seen    = 0;
		readings_sent   = 0;
		settings_written = 1;
		idle_cycles     = 0;
		last_heading    = 0;
		fail_burst_left = 0;
		stall_seg_left  = 0;
		foreach (act_tally[a])
			act_tally[a] = 0;
		reset_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r])
			repeat (dir_rows[r].reps) send_reading(dir_rows[r]);
		settle_block();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			choose_settings(phase);
			for (int n = 0; n < READS_PER_PHASE; n++) begin
				quiet = (n >= 120 && n < 160);
				random_reading();
			end
			quiet = 1'b0;
			settle_block();
		end

		$display("%0d readings over %0d register settings, %0d results checked, %0d mismatches",
			readings_sent, settings_written, results_seen, mismatch_count);
		$display("steps: alarm %0d lost %0d recovered %0d left %0d right %0d turning %0d done %0d track %0d",
			act_tally[ACT_ALARM], act_tally[ACT_LOST], act_tally[ACT_RECOVERED],
			act_tally[ACT_LEFT_BEGIN], act_tally[ACT_RIGHT_BEGIN], act_tally[ACT_TURNING],
			act_tally[ACT_TURN_DONE], act_tally[ACT_TRACKING]);
		if (mismatch_count == 0 && steering_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/lfhs_pkg.sv
design/lfhs_regs.sv
design/lfhs_dp.sv
design/lfhs_ctrl.sv
design/line_follow_heading_sequencer_unit.sv
bench/testbench.sv
